### design/shell_line_tokenizer_assert.svh
// Assertion macros used by the tokenizer's top-level RTL file.
`ifndef SHELL_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed one cycle later");

`endif

### design/slt_pkg.sv
package slt_pkg;

   // Line limit and the widths that follow from it.
   localparam int MAX_LINE = 4096;
   localparam int START_W  = $clog2(MAX_LINE);
   localparam int LEN_W    = START_W + 1;
   localparam logic [START_W-1:0] POS_LAST = START_W'(MAX_LINE - 1);

   // Depth of the token group queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Character codes the tokenizer reacts to.
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef enum logic [2:0] {
      KIND_WORD    = 3'd0,
      KIND_OUT     = 3'd1,
      KIND_APPEND  = 3'd2,
      KIND_IN      = 3'd3,
      KIND_HEREDOC = 3'd4,
      KIND_PIPE    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_GT   = 2'd1,
      OP_LT   = 2'd2
   } pend_op_type;

   typedef struct packed {
      kind_type               kind;
      logic [START_W-1:0]     start;
      logic [LEN_W-1:0]       length;
   } token_type;

   // All tokens caused by one input byte: one or two of them.
   typedef struct packed {
      logic      two;
      token_type tok_a;
      token_type tok_b;
   } group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic token_type make_token(input kind_type kind,
                                            input logic [START_W-1:0] start,
                                            input logic [LEN_W-1:0] length);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      return t;
   endfunction

   // Operator length: two bytes for a doubled operator, cut to the room left.
   function automatic logic [LEN_W-1:0] op_length(input logic [START_W-1:0] start,
                                                 input logic doubled);
      logic [LEN_W-1:0] len;
      len = doubled ? LEN_W'(2) : LEN_W'(1);
      if (start == POS_LAST) begin
         len = LEN_W'(1);
      end
      return len;
   endfunction

endpackage

### design/slt_front.sv
module slt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                chunk_last,
   output logic                grp_push,
   output slt_pkg::group_type  grp_data
);

   logic [slt_pkg::START_W-1:0] pos_ff, pos_in;
   logic                        in_word_ff, in_word_in;
   logic [slt_pkg::START_W-1:0] begin_ff, begin_in;
   logic                        quote_ff, quote_in;
   logic                        dquote_ff, dquote_in;
   slt_pkg::pend_op_type        op_ff, op_in;

   // Classify the byte, update the scan state and collect the tokens it ends.
   always_comb begin
      logic                 used;
      logic [1:0]           n;
      logic                 is_q;
      logic                 is_dq;
      logic [7:0]           opc;
      slt_pkg::token_type   e;
      slt_pkg::token_type   toks [2];
      logic [slt_pkg::LEN_W-1:0] wlen;

      used       = 1'b0;
      n          = 2'd0;
      toks[0]    = '0;
      toks[1]    = '0;
      e          = '0;
      is_q       = (char_byte == slt_pkg::CHAR_SQUOTE) || (char_byte == slt_pkg::CHAR_DQUOTE);
      is_dq      = (char_byte == slt_pkg::CHAR_DQUOTE);
      opc        = (op_ff == slt_pkg::OP_GT) ? slt_pkg::CHAR_GT : slt_pkg::CHAR_LT;
      pos_in     = pos_ff;
      in_word_in = in_word_ff;
      begin_in   = begin_ff;
      quote_in   = quote_ff;
      dquote_in  = dquote_ff;
      op_in      = op_ff;
      wlen       = '0;

      // A pending operator either doubles with this byte or is closed by it.
      if (op_ff != slt_pkg::OP_NONE) begin
         if (char_byte == opc) begin
            e = slt_pkg::make_token((op_ff == slt_pkg::OP_GT) ? slt_pkg::KIND_APPEND
                                                             : slt_pkg::KIND_HEREDOC,
                                    begin_ff, slt_pkg::op_length(begin_ff, 1'b1));
            used = 1'b1;
         end else begin
            e = slt_pkg::make_token((op_ff == slt_pkg::OP_GT) ? slt_pkg::KIND_OUT
                                                             : slt_pkg::KIND_IN,
                                    begin_ff, slt_pkg::op_length(begin_ff, 1'b0));
         end
         toks[n[0]] = e;
         n          = n + 2'd1;
         op_in      = slt_pkg::OP_NONE;
      end

      // Inside an open word: quotes toggle, blanks and operators end it.
      if (!used && in_word_ff) begin
         if (quote_ff) begin
            if (is_q && (is_dq == dquote_ff)) begin
               quote_in = 1'b0;
            end
            used = 1'b1;
         end else if (is_q) begin
            quote_in  = 1'b1;
            dquote_in = is_dq;
            used      = 1'b1;
         end else if (slt_pkg::is_blank(char_byte) || (char_byte == slt_pkg::CHAR_GT) ||
                      (char_byte == slt_pkg::CHAR_LT) || (char_byte == slt_pkg::CHAR_PIPE)) begin
            wlen = (pos_ff > begin_ff) ? ({1'b0, pos_ff} - {1'b0, begin_ff})
                                       : slt_pkg::LEN_W'(1);
            toks[n[0]] = slt_pkg::make_token(slt_pkg::KIND_WORD, begin_ff, wlen);
            n          = n + 2'd1;
            in_word_in = 1'b0;
         end else begin
            used = 1'b1;
         end
      end

      // Outside a word: a pipe, the start of an operator, or a new word.
      if (!used && !slt_pkg::is_blank(char_byte)) begin
         if (char_byte == slt_pkg::CHAR_PIPE) begin
            toks[n[0]] = slt_pkg::make_token(slt_pkg::KIND_PIPE, pos_ff,
                                             slt_pkg::LEN_W'(1));
            n          = n + 2'd1;
         end else if ((char_byte == slt_pkg::CHAR_GT) || (char_byte == slt_pkg::CHAR_LT)) begin
            op_in    = (char_byte == slt_pkg::CHAR_GT) ? slt_pkg::OP_GT : slt_pkg::OP_LT;
            begin_in = pos_ff;
         end else begin
            in_word_in = 1'b1;
            begin_in   = pos_ff;
            if (is_q) begin
               quote_in  = 1'b1;
               dquote_in = is_dq;
            end
         end
      end

      // The last byte flushes what is still open and clears the state.
      if (chunk_last) begin
         if (op_in != slt_pkg::OP_NONE) begin
            toks[n[0]] = slt_pkg::make_token((op_in == slt_pkg::OP_GT) ? slt_pkg::KIND_OUT
                                                                      : slt_pkg::KIND_IN,
                                             begin_in, slt_pkg::op_length(begin_in, 1'b0));
            n          = n + 2'd1;
         end else if (in_word_in) begin
            wlen = {1'b0, pos_ff} + slt_pkg::LEN_W'(1) - {1'b0, begin_in};
            toks[n[0]] = slt_pkg::make_token(slt_pkg::KIND_WORD, begin_in, wlen);
            n          = n + 2'd1;
         end
         pos_in     = '0;
         in_word_in = 1'b0;
         begin_in   = '0;
         quote_in   = 1'b0;
         dquote_in  = 1'b0;
         op_in      = slt_pkg::OP_NONE;
      end else if (pos_ff != slt_pkg::POS_LAST) begin
         pos_in = pos_ff + slt_pkg::START_W'(1);
      end

      grp_push       = accept && (n != 2'd0);
      grp_data.two   = (n == 2'd2);
      grp_data.tok_a = toks[0];
      grp_data.tok_b = toks[1];
   end

   // Scan state advances on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         in_word_ff <= 1'b0;
         begin_ff   <= '0;
         quote_ff   <= 1'b0;
         dquote_ff  <= 1'b0;
         op_ff      <= slt_pkg::OP_NONE;
      end else if (accept) begin
         pos_ff     <= pos_in;
         in_word_ff <= in_word_in;
         begin_ff   <= begin_in;
         quote_ff   <= quote_in;
         dquote_ff  <= dquote_in;
         op_ff      <= op_in;
      end
   end

endmodule

### design/slt_queue.sv
module slt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  slt_pkg::group_type        push_data,
   input  logic                      pop,
   output slt_pkg::group_type        head,
   output slt_pkg::queue_status_type status
);

   slt_pkg::group_type               slot_ff [slt_pkg::QUEUE_DEPTH];
   slt_pkg::group_type               slot_in [slt_pkg::QUEUE_DEPTH];
   logic [slt_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic [slt_pkg::QPTR_W-1:0]       tail;

   // Fill count bookkeeping.
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + slt_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - slt_pkg::QCNT_W'(1);
      end
   end

   // Groups move toward slot zero as the head leaves; a new group lands behind the last one.
   always_comb begin
      tail = pop ? cnt_ff[slt_pkg::QPTR_W-1:0] - slt_pkg::QPTR_W'(1)
                 : cnt_ff[slt_pkg::QPTR_W-1:0];
      for (int i = 0; i < slt_pkg::QUEUE_DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i + 1] : slot_ff[i];
      end
      slot_in[slt_pkg::QUEUE_DEPTH - 1] = slot_ff[slt_pkg::QUEUE_DEPTH - 1];
      if (push) begin
         slot_in[tail] = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Group storage; the oldest group always sits in slot zero.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign head         = slot_ff[0];
   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == slt_pkg::QCNT_W'(slt_pkg::QUEUE_DEPTH));

endmodule

### design/slt_back.sv
module slt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  slt_pkg::group_type         head,
   input  logic                       q_empty,
   input  logic                       take,
   output logic                       q_pop,
   output logic                       second_sel,
   output slt_pkg::token_type         tok,
   output logic                       last_of_run
);

   logic sel_ff, sel_in;
   logic group_done;

   // Hand out the head group's tokens one beat at a time.
   always_comb begin
      group_done  = take && (sel_ff || !head.two);
      q_pop       = group_done && !q_empty;
      sel_in      = sel_ff;
      if (take) begin
         sel_in = !group_done;
      end
      tok         = sel_ff ? head.tok_b : head.tok_a;
      last_of_run = sel_ff || !head.two;
      second_sel  = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

### design/shell_line_tokenizer.sv
// Channel   Ports                                          Handshake
// input     req_char_byte, req_chunk_last                  push / full
// result    rsp_token_{kind,start,length}, rsp_last_of_run  empty / pop
//
// One byte is taken in every cycle while the group queue has room; the scan
// state updates in that same cycle. A byte ends zero, one or two tokens; each
// token leaves on its own result beat, so a byte with two tokens holds the
// output until both have been popped. The four-entry group queue sets how far
// the input side runs ahead of a stalled consumer. Reset is synchronous and
// clears the scan state and the queue.
module shell_line_tokenizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [7:0]                     req_char_byte,
   input  logic                           req_chunk_last,
   output logic                           empty,
   input  logic                           pop,
   output logic [2:0]                     rsp_token_kind,
   output logic [slt_pkg::START_W-1:0]    rsp_token_start,
   output logic [slt_pkg::LEN_W-1:0]      rsp_token_length,
   output logic                           rsp_last_of_run
);

`include "shell_line_tokenizer_assert.svh"

   logic                      accept;
   logic                      grp_push;
   slt_pkg::group_type        grp_data;
   slt_pkg::group_type        head;
   slt_pkg::queue_status_type q_status;
   logic                      q_pop;
   logic                      take;
   logic                      second_sel;
   slt_pkg::token_type        tok;

   // Beat handshakes on both sides.
   assign accept = push && !q_status.full;
   assign take   = pop && !q_status.empty;
   assign full   = q_status.full;
   assign empty  = q_status.empty;

   slt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_char_byte),
      .chunk_last (req_chunk_last),
      .grp_push   (grp_push),
      .grp_data   (grp_data)
   );

   slt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   slt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_empty     (q_status.empty),
      .take        (take),
      .q_pop       (q_pop),
      .second_sel  (second_sel),
      .tok         (tok),
      .last_of_run (rsp_last_of_run)
   );

   assign rsp_token_kind   = tok.kind;
   assign rsp_token_start  = tok.start;
   assign rsp_token_length = tok.length;

   // The queue is never written while it is full.
   `SLT_ASSERT_SAME(a_no_push_full, clock, reset, grp_push, !q_status.full)
   // The first token of a pair leaves its partner waiting as the last of run.
   `SLT_ASSERT_NEXT(a_pair_follows, clock, reset, take && !rsp_last_of_run,
                    !empty && rsp_last_of_run && second_sel)
   // A shown token always spans at least one byte.
   `SLT_ASSERT_SAME(a_len_nonzero, clock, reset, !empty, rsp_token_length != '0)
   // The second token of a pair is only served from a two-token group.
   `SLT_ASSERT_SAME(a_sel_pair, clock, reset, !empty && second_sel, head.two)

endmodule
